// ===== rtl/core/obmg_pkg.sv =====
// Package for the odd-byte mask group codec.
// Holds the channel payload types, the job record passed front to back, and shared constants.
// No dependencies.
package obmg_pkg;

  localparam int unsigned GroupData  = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NumBanks   = 2;

  localparam logic [2:0] GROUP_LAST = 3'd6;
  localparam logic [7:0] MASK_INIT  = 8'h01;

  localparam logic JOB_SINGLE = 1'b0;
  localparam logic JOB_GROUP  = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_end;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] cnt;
    logic       bank;
    logic       last;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef struct packed {
    logic       bank;
    logic [2:0] idx;
  } buf_rd_t;

endpackage

// ===== rtl/core/obmg_front.sv =====
// Front end of the codec: takes requests, tracks group state, fills the group banks.
// Emits one job per group flush or per decoded byte; serves bank reads for the back end.
// Depends on obmg_pkg.
module obmg_front import obmg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output logic      cfg_ready,
  input  logic      in_valid,
  input  in_item_t  in_payload,
  output logic      in_ready,
  output logic      push_valid,
  output job_t      push_job,
  input  logic      push_ready,
  input  buf_rd_t   rd_req,
  output logic [7:0] rd_data,
  input  release_t  rel
);

  logic                direction_r, direction_nxt;
  logic [2:0]          fill_r, fill_nxt;
  logic [7:0]          mask_r, mask_nxt;
  logic [7:0]          dmask_r, dmask_nxt;
  logic                wr_bank_r, wr_bank_nxt;
  logic [NumBanks-1:0] busy_r, busy_nxt;
  logic [7:0]          buf_r [NumBanks][GroupData];

  logic       accept;
  logic [2:0] pos;
  logic [7:0] stored;
  logic [7:0] mask_upd;
  logic [7:0] dec_byte;
  logic       flush;

  assign cfg_ready = 1'b1;
  assign in_ready  = !cfg_valid && push_ready &&
                     ((direction_r == DIR_DECODE) || !busy_r[wr_bank_r]);
  assign accept    = in_valid && in_ready;
  assign pos       = fill_r;
  assign stored    = in_payload.data_byte | 8'h01;
  assign mask_upd  = mask_r | ({7'd0, in_payload.data_byte[0]} << (pos + 3'd1));
  assign flush     = (pos == GROUP_LAST) || in_payload.msg_last;
  assign dec_byte  = dmask_r[pos] ? in_payload.data_byte : in_payload.data_byte - 8'd1;
  assign rd_data   = buf_r[rd_req.bank][rd_req.idx];

  always_comb begin
    push_valid = 1'b0;
    push_job   = '{kind: JOB_GROUP, data: mask_upd, cnt: pos, bank: wr_bank_r,
                   last: in_payload.msg_last};
    if (direction_r == DIR_DECODE) begin
      push_valid = accept && (pos != 3'd0);
      push_job   = '{kind: JOB_SINGLE, data: dec_byte, cnt: 3'd0, bank: 1'b0,
                     last: in_payload.msg_last};
    end else begin
      push_valid = accept && flush;
    end
  end

  always_comb begin
    direction_nxt = direction_r;
    fill_nxt      = fill_r;
    mask_nxt      = mask_r;
    dmask_nxt     = dmask_r;
    wr_bank_nxt   = wr_bank_r;
    busy_nxt      = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (cfg_valid) begin
      direction_nxt = cfg_data;
      fill_nxt      = 3'd0;
      mask_nxt      = MASK_INIT;
      dmask_nxt     = 8'd0;
    end else if (accept) begin
      if (direction_r == DIR_DECODE) begin
        if (pos == 3'd0) begin
          dmask_nxt = in_payload.data_byte;
        end
        fill_nxt = in_payload.msg_last ? 3'd0 : pos + 3'd1;
      end else if (flush) begin
        busy_nxt[wr_bank_r] = 1'b1;
        wr_bank_nxt         = !wr_bank_r;
        fill_nxt            = 3'd0;
        mask_nxt            = MASK_INIT;
      end else begin
        fill_nxt = pos + 3'd1;
        mask_nxt = mask_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      fill_r      <= 3'd0;
      mask_r      <= MASK_INIT;
      dmask_r     <= 8'd0;
      wr_bank_r   <= 1'b0;
      busy_r      <= '0;
    end else begin
      direction_r <= direction_nxt;
      fill_r      <= fill_nxt;
      mask_r      <= mask_nxt;
      dmask_r     <= dmask_nxt;
      wr_bank_r   <= wr_bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (direction_r == DIR_ENCODE)) begin
      buf_r[wr_bank_r][pos] <= stored;
    end
  end

endmodule

// ===== rtl/core/obmg_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on obmg_pkg.
module obmg_queue import obmg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            q_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/obmg_back.sv =====
// Back end of the codec: runs jobs from the queue and drives the output register.
// A group job sends the mask byte, then reads its bank one byte per cycle while the output is not stalled.
// Depends on obmg_pkg.
module obmg_back import obmg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  job_t       pop_job,
  output logic       pop_ready,
  output buf_rd_t    rd_req,
  input  logic [7:0] rd_data,
  output release_t   rel,
  output logic       out_valid,
  output out_item_t  out_payload,
  input  logic       out_ready
);

  logic       active_r, active_nxt;
  job_t       job_r, job_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic       can_load;
  logic [2:0] rd_idx;
  logic       last_byte;

  assign can_load    = !out_valid_r || out_ready;
  assign pop_ready   = !active_r && can_load;
  assign rd_idx      = idx_r - 3'd1;
  assign rd_req      = '{bank: job_r.bank, idx: rd_idx};
  assign last_byte   = (rd_idx == job_r.cnt);
  assign rel         = '{valid: active_r && can_load && last_byte, bank: job_r.bank};
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    active_nxt    = active_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (can_load) begin
      out_valid_nxt = 1'b0;
      if (active_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{out_byte: rd_data, run_last: last_byte,
                          msg_end: last_byte && job_r.last};
        if (last_byte) begin
          active_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end else if (pop_valid) begin
        out_valid_nxt = 1'b1;
        if (pop_job.kind == JOB_SINGLE) begin
          out_nxt = '{out_byte: pop_job.data, run_last: 1'b1, msg_end: pop_job.last};
        end else begin
          out_nxt    = '{out_byte: pop_job.data, run_last: 1'b0, msg_end: 1'b0};
          active_nxt = 1'b1;
          job_nxt    = pop_job;
          idx_nxt    = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd1;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/core/odd_byte_mask_group_codec.sv =====
// Top level of the odd-byte mask group codec: front end, job queue, back end.
// Depends on obmg_pkg, obmg_front, obmg_queue, obmg_back.
//
//   channel  handshake             payload
//   in       in_valid/in_ready     in_payload  (in_item_t: data_byte, msg_last)
//   out      out_valid/out_ready   out_payload (out_item_t: out_byte, run_last, msg_end)
//   cfg      cfg_valid/cfg_ready   cfg_data    (direction)
//
// Encode: one request per cycle into a group bank while not stalled; a full or final
// group costs mask + n bytes, sent one byte per cycle from the back end while the
// output is not stalled.
// Decode: one request per cycle while not stalled, one output byte per data request.
// Two group banks and a two-entry job queue let input and output stall independently.
// A direction write holds the input for that cycle.
// Reset is synchronous; no clearing pass, the block is ready the cycle after reset.
module odd_byte_mask_group_codec import obmg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_payload,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_payload
);

  logic       push_valid, push_ready;
  job_t       push_job;
  logic       pop_valid, pop_ready;
  job_t       pop_job;
  buf_rd_t    rd_req;
  logic [7:0] rd_data;
  release_t   rel;

  obmg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .rel        (rel)
  );

  obmg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  obmg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_job     (pop_job),
    .pop_ready   (pop_ready),
    .rd_req      (rd_req),
    .rd_data     (rd_data),
    .rel         (rel),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .out_ready   (out_ready)
  );

  a_msg_end_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.msg_end |-> out_payload.run_last)
    else $error("msg_end without run_last");

  a_push_has_room : assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("job pushed into full queue");

  a_pop_ready_idle_back : assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> out_valid)
    else $error("popped job produced no output");

  a_reset_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for odd_byte_mask_group_codec: encode and decode traffic,
// direction writes, random stalls on both channels, long output hold-off.
// Depends on obmg_pkg and the codec RTL.
module tb_top;
  import obmg_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 24;
  localparam int HoldTicks   = 90;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  logic      cfg_data   = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  in_item_t  in_payload = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  out_item_t out_payload;

  // codec state mirror
  logic       m_dir;
  logic [2:0] m_fill;
  logic [7:0] m_gmask;
  logic [7:0] m_dmask;
  logic [7:0] m_buf [GroupData];

  out_item_t due_bytes[$];
  int        n_errors    = 0;
  int        n_requests  = 0;
  int        n_results   = 0;
  int        n_messages  = 0;
  int        n_dir_write = 0;
  int        cycles      = 0;
  int        hold_cycles = 0;
  bit        calm        = 1'b0;

  odd_byte_mask_group_codec u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic void clear_groups();
    m_fill  = 3'd0;
    m_gmask = MASK_INIT;
    m_dmask = 8'h00;
  endfunction

  function automatic void codec_apply(in_item_t it);
    logic [2:0] pos;
    logic [7:0] b;
    out_item_t  r;
    logic [2:0] i;
    b = it.data_byte;
    if (m_dir == DIR_ENCODE) begin
      pos = (m_fill > GROUP_LAST) ? GROUP_LAST : m_fill;
      if (!b[0]) begin
        m_buf[pos] = b + 8'd1;
      end else begin
        m_buf[pos] = b;
        m_gmask = m_gmask | (8'd1 << (pos + 3'd1));
      end
      if (pos == GROUP_LAST || it.msg_last) begin
        r.out_byte = m_gmask;
        r.run_last = 1'b0;
        r.msg_end  = 1'b0;
        due_bytes = {due_bytes, r};
        for (i = 3'd0; i <= pos; i++) begin
          r.out_byte = m_buf[i];
          r.run_last = (i == pos);
          r.msg_end  = it.msg_last && (i == pos);
          due_bytes = {due_bytes, r};
        end
        m_fill  = 3'd0;
        m_gmask = MASK_INIT;
      end else begin
        m_fill = pos + 3'd1;
      end
    end else begin
      pos = m_fill;
      if (pos == 3'd0) begin
        m_dmask = b;
      end else begin
        r.out_byte = m_dmask[pos] ? b : b - 8'd1;
        r.run_last = 1'b1;
        r.msg_end  = it.msg_last;
        due_bytes = {due_bytes, r};
      end
      m_fill = it.msg_last ? 3'd0 : pos + 3'd1;
    end
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch %s: got %02h want %02h (result %0d, cycle %0d)",
               what, got, want, n_results, cycles);
  endtask

  // result checker: sample at the edge, compare once the sender has predicted
  always begin
    logic      fire;
    out_item_t got;
    out_item_t want;
    @(posedge clk);
    fire = rst_n && out_valid && out_ready;
    got  = out_payload;
    #1;
    if (fire) begin
      n_results++;
      if (due_bytes.size() == 0) begin
        report("unexpected byte", got.out_byte, 8'h00);
      end else begin
        want = due_bytes.pop_front();
        if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
        if (got.run_last !== want.run_last)
          report("run_last", {7'd0, got.run_last}, {7'd0, want.run_last});
        if (got.msg_end !== want.msg_end)
          report("msg_end", {7'd0, got.msg_end}, {7'd0, want.msg_end});
      end
    end
  end

  // receiver: random stall bursts, or a long hold-off on request
  always begin
    @(posedge clk);
    if (hold_cycles != 0) begin
      out_ready <= 1'b0;
      repeat (hold_cycles) @(posedge clk);
      hold_cycles = 0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    codec_apply(it);
    n_requests++;
    if (it.msg_last) n_messages++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic set_direction(logic d);
    wait_drained();
    repeat (SettleTicks) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_dir = d;
    clear_groups();
    n_dir_write++;
  endtask

  // cut drops the end marker, leaving a partial group for a direction write
  task automatic send_message(int len, bit cut);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       it.data_byte = 8'h00;
        1:       it.data_byte = 8'hFF;
        2:       it.data_byte = 8'hFE;
        default: it.data_byte = 8'($urandom_range(0, 255));
      endcase
      it.msg_last = !cut && (i == len - 1);
      send_item(it);
    end
  endtask

  task automatic test_encode_edges();
    set_direction(DIR_ENCODE);
    send_item({8'h00, 1'b1});
    send_item({8'hFF, 1'b1});
    send_item({8'h00, 1'b0});
    send_item({8'hFF, 1'b0});
    send_item({8'h80, 1'b0});
    send_item({8'h7F, 1'b0});
    send_item({8'hFE, 1'b0});
    send_item({8'h01, 1'b0});
    send_item({8'h02, 1'b0});
    send_item({8'h55, 1'b1});
  endtask

  task automatic test_decode_edges();
    set_direction(DIR_DECODE);
    send_item({8'hAA, 1'b0});
    send_item({8'h00, 1'b0});
    send_item({8'hFF, 1'b1});
    send_item({8'h00, 1'b1});
    send_item({8'h55, 1'b0});
    send_item({8'h00, 1'b0});
    send_item({8'h01, 1'b0});
    send_item({8'hFE, 1'b0});
    send_item({8'hFF, 1'b0});
    send_item({8'h80, 1'b0});
    send_item({8'h7F, 1'b0});
    send_item({8'h02, 1'b0});
    send_item({8'h81, 1'b0});
    send_item({8'h00, 1'b1});
  endtask

  task automatic test_direction_drop();
    set_direction(DIR_ENCODE);
    send_item({8'h2A, 1'b0});
    send_item({8'h3B, 1'b0});
    set_direction(DIR_ENCODE);
    send_item({8'h10, 1'b1});
    set_direction(DIR_DECODE);
    send_item({8'hFE, 1'b0});
    send_item({8'h00, 1'b0});
    set_direction(DIR_DECODE);
    send_item({8'h03, 1'b0});
    send_item({8'h04, 1'b1});
  endtask

  task automatic test_random_encode(int target);
    int start;
    start = n_requests;
    set_direction(DIR_ENCODE);
    while (n_requests - start < target)
      send_message($urandom_range(1, 20), 1'b0);
  endtask

  task automatic test_random_decode(int target);
    int start;
    start = n_requests;
    set_direction(DIR_DECODE);
    while (n_requests - start < target)
      send_message($urandom_range(1, 24), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_output_hold();
    set_direction(DIR_ENCODE);
    hold_cycles = HoldTicks;
    send_message(28, 1'b0);
    wait_drained();
    set_direction(DIR_DECODE);
    hold_cycles = HoldTicks;
    send_message(20, 1'b0);
    wait_drained();
  endtask

  task automatic test_calm_mixed(int target);
    int start;
    start = n_requests;
    calm  = 1'b1;
    while (n_requests - start < target) begin
      if ($urandom_range(0, 3) == 0) set_direction(1'($urandom_range(0, 1)));
      send_message($urandom_range(1, 18), $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    m_dir = DIR_ENCODE;
    clear_groups();
    @(posedge clk);

    test_encode_edges();
    test_decode_edges();
    test_direction_drop();
    test_random_encode(130);
    test_output_hold();
    test_random_decode(130);
    test_calm_mixed(100);

    wait_drained();
    repeat (SettleTicks) @(posedge clk);
    if (due_bytes.size() != 0) report("left over", 8'h00, 8'(due_bytes.size()));
    $display("covered %0d requests, %0d messages, %0d result bytes, %0d direction writes",
             n_requests, n_messages, n_results, n_dir_write);
    $display("both directions, full and short groups, mask-only endings, dropped groups, hold-off");
    if (n_errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== odd_byte_mask_group_codec.f =====
rtl/core/obmg_pkg.sv
rtl/core/obmg_front.sv
rtl/core/obmg_queue.sv
rtl/core/obmg_back.sv
rtl/core/odd_byte_mask_group_codec.sv
tb/tb_top.sv
